@@ design/fdf_pkg.sv @@
package fdf_pkg;

	localparam int NCOEF = 8;
	localparam int IDX_W = 3;

	typedef struct packed {
		logic valid;
		logic last;
	} fdf_ctl_t;

endpackage

@@ design/fdf_tap_cell.sv @@
module fdf_tap_cell #(
	parameter int SAMPLE_BITS = 24,
	parameter int COEF_BITS   = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  shift,
	input  logic                                  load,
	input  logic signed [SAMPLE_BITS-1:0]           nxt,
	input  logic signed [COEF_BITS-1:0]             coef,
	output logic signed [SAMPLE_BITS-1:0]           smp,
	output logic signed [SAMPLE_BITS+COEF_BITS-1:0] prod_s1
);

	localparam int PW = SAMPLE_BITS + COEF_BITS;

	logic signed [SAMPLE_BITS-1:0] hist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (shift) begin
			hist_q <= nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			prod_s1 <= PW'(hist_q) * PW'(coef);
		end
	end

	assign smp = hist_q;

endmodule

@@ design/fdf_accum.sv @@
module fdf_accum #(
	parameter int TAPS        = 8,
	parameter int SAMPLE_BITS = 24,
	parameter int COEF_BITS   = 16,
	parameter int OW          = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic signed [SAMPLE_BITS+COEF_BITS-1:0] prod [TAPS],
	input  fdf_pkg::fdf_ctl_t                     ctl,
	output logic                                  take,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [OW-1:0]                         m_axis_tdata,
	output logic                                  m_axis_tlast
);

	import fdf_pkg::*;

	localparam int PW    = SAMPLE_BITS + COEF_BITS;
	localparam int NP    = (TAPS + 1) / 2;
	localparam int ACC_W = PW + $clog2(TAPS) + 1;
	localparam int F     = COEF_BITS - 1;
	localparam int RW    = ACC_W - F;

	localparam logic signed [ACC_W-1:0] BIAS = ACC_W'(1) << (F - 1);
	localparam logic signed [RW-1:0] HI = {{(RW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [RW-1:0] LO = {{(RW-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

	logic signed [PW:0]      pair_d  [NP];
	logic signed [PW:0]      pair_s2 [NP];
	logic signed [ACC_W-1:0] acc_d;
	logic signed [ACC_W-1:0] acc_s3;
	logic signed [RW-1:0]    rs;
	logic [OW-1:0]           tdata_d;
	logic                    v2_q, v3_q;
	logic                    l2_q, l3_q;
	logic                    rdy_o, rdy3, rdy2;

	assign rdy_o = !m_axis_tvalid || m_axis_tready;
	assign rdy3  = !v3_q || rdy_o;
	assign rdy2  = !v2_q || rdy3;
	assign take  = rdy2;

	// pairwise partial sums
	for (genvar j = 0; j < NP; j++) begin : g_pair
		if (2 * j + 1 < TAPS) begin : g_two
			assign pair_d[j] = (PW+1)'(prod[2*j]) + (PW+1)'(prod[2*j+1]);
		end else begin : g_one
			assign pair_d[j] = (PW+1)'(prod[2*j]);
		end
	end

	always_comb begin
		acc_d = BIAS;
		for (int j = 0; j < NP; j++) begin
			acc_d = acc_d + ACC_W'(pair_s2[j]);
		end
	end

	// floor shift then clip
	always_comb begin
		rs      = acc_s3[ACC_W-1:F];
		tdata_d = '0;
		if (rs > HI) begin
			tdata_d[SAMPLE_BITS-1:0] = HI[SAMPLE_BITS-1:0];
			tdata_d[SAMPLE_BITS]     = 1'b1;
		end else if (rs < LO) begin
			tdata_d[SAMPLE_BITS-1:0] = LO[SAMPLE_BITS-1:0];
			tdata_d[SAMPLE_BITS]     = 1'b1;
		end else begin
			tdata_d[SAMPLE_BITS-1:0] = rs[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q          <= 1'b0;
			v3_q          <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (rdy2) begin
				v2_q <= ctl.valid;
			end
			if (rdy3) begin
				v3_q <= v2_q;
			end
			if (rdy_o) begin
				m_axis_tvalid <= v3_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			pair_s2 <= pair_d;
			l2_q    <= ctl.last;
		end
		if (rdy3) begin
			acc_s3 <= acc_d;
			l3_q   <= l2_q;
		end
		if (rdy_o) begin
			m_axis_tdata <= tdata_d;
			m_axis_tlast <= l3_q;
		end
	end

endmodule

@@ design/fractional_delay_fir_frame_core.sv @@
// path: an accepted sample is registered in the tap cells, then in the product, pair-sum,
//   accumulator and output registers before its word appears on m_axis
// throughput: one sample per cycle while m_axis_tready does not stall the pipeline; a frame-end
//   sample holds s_axis_tready low while the zero-padded tail is shifted out
// reset: asynchronous, clears history, fill count and pipeline valids; coefficients
//   return to unity at the center tap and zero elsewhere
module fractional_delay_fir_frame_core #(
	parameter int TAPS        = 8,
	parameter int SAMPLE_BITS = 24,
	parameter int COEF_BITS   = 16,
	localparam int IW = ((SAMPLE_BITS + 7) / 8) * 8,
	localparam int OW = ((SAMPLE_BITS + 1 + 7) / 8) * 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [IW-1:0]             s_axis_tdata,   // sample
	input  logic                      s_axis_tlast,   // frame_end
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [OW-1:0]             m_axis_tdata,   // filtered_sample, saturated
	output logic                      m_axis_tlast,   // last_of_frame
	input  logic                      cfg_we,
	input  logic [fdf_pkg::IDX_W-1:0] cfg_idx,
	input  logic [COEF_BITS-1:0]      cfg_data
);

	import fdf_pkg::*;

	localparam int PW   = SAMPLE_BITS + COEF_BITS;
	localparam int HALF = TAPS / 2;
	localparam int LAT  = TAPS - 1 - HALF;
	localparam int FW   = $clog2(LAT + 2);
	localparam logic [FW-1:0] LAT_C = FW'(LAT);
	localparam logic signed [COEF_BITS-1:0] UNITY = {1'b0, {(COEF_BITS-1){1'b1}}};

	logic signed [COEF_BITS-1:0]   coef_q [TAPS];
	logic signed [SAMPLE_BITS-1:0] hist   [1:TAPS-1];
	logic signed [PW-1:0]          prod   [TAPS];
	logic signed [SAMPLE_BITS-1:0] in_val;
	logic [FW-1:0]                 fill_q, dcnt_q, dsel;
	logic                          flush_q, fresh_q;
	logic                          v0_q, l0_q;
	fdf_ctl_t                      ctl_s1;
	logic                          take, rdy0, rdy1, step, emit, end_now;

	assign rdy1          = !ctl_s1.valid || take;
	assign rdy0          = !v0_q || rdy1;
	assign s_axis_tready = rdy0 && !flush_q;
	assign step          = flush_q ? rdy0 : (s_axis_tvalid && rdy0);
	assign in_val        = flush_q ? '0 : s_axis_tdata[SAMPLE_BITS-1:0];
	assign dsel          = flush_q ? dcnt_q : '0;
	assign emit          = ({1'b0, fill_q} + {1'b0, dsel}) >= {1'b0, LAT_C};
	assign end_now       = flush_q ? (dcnt_q == LAT_C) : (s_axis_tlast && (LAT_C == '0));

	// coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TAPS; k++) begin
				coef_q[k] <= (k == HALF) ? UNITY : '0;
			end
		end else if (cfg_we) begin
			for (int k = 0; k < TAPS; k++) begin
				if (cfg_idx == IDX_W'(k)) begin
					coef_q[k] <= cfg_data;
				end
			end
		end
	end

	// frame sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			dcnt_q  <= '0;
			flush_q <= 1'b0;
			fresh_q <= 1'b0;
			v0_q    <= 1'b0;
			l0_q    <= 1'b0;
		end else begin
			if (rdy0) begin
				v0_q <= step && emit;
				l0_q <= end_now;
			end
			if (step) begin
				fresh_q <= end_now;
				if (!flush_q) begin
					if (s_axis_tlast) begin
						if (end_now) begin
							fill_q <= '0;
						end else begin
							flush_q <= 1'b1;
							dcnt_q  <= FW'(1);
						end
					end else if (fill_q != LAT_C) begin
						fill_q <= fill_q + 1'b1;
					end
				end else begin
					if (end_now) begin
						flush_q <= 1'b0;
						fill_q  <= '0;
					end else begin
						dcnt_q <= dcnt_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1.valid <= 1'b0;
			ctl_s1.last  <= 1'b0;
		end else if (rdy1) begin
			ctl_s1.valid <= v0_q;
			ctl_s1.last  <= l0_q;
		end
	end

	// delay line, one tap per cell, oldest in cell 0
	for (genvar k = 0; k < TAPS; k++) begin : g_tap
		logic signed [SAMPLE_BITS-1:0] nxt;
		if (k == TAPS - 1) begin : g_head
			assign nxt = in_val;
		end else begin : g_link
			assign nxt = fresh_q ? '0 : hist[k+1];
		end
		if (k == 0) begin : g_oldest
			fdf_tap_cell #(
				.SAMPLE_BITS(SAMPLE_BITS),
				.COEF_BITS  (COEF_BITS)
			) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (step),
				.load   (rdy1),
				.nxt    (nxt),
				.coef   (coef_q[k]),
				.smp    (),
				.prod_s1(prod[k])
			);
		end else begin : g_inner
			fdf_tap_cell #(
				.SAMPLE_BITS(SAMPLE_BITS),
				.COEF_BITS  (COEF_BITS)
			) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (step),
				.load   (rdy1),
				.nxt    (nxt),
				.coef   (coef_q[k]),
				.smp    (hist[k]),
				.prod_s1(prod[k])
			);
		end
	end

	fdf_accum #(
		.TAPS       (TAPS),
		.SAMPLE_BITS(SAMPLE_BITS),
		.COEF_BITS  (COEF_BITS),
		.OW         (OW)
	) u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.prod         (prod),
		.ctl          (ctl_s1),
		.take         (take),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

endmodule

@@ design/fdf_chk.sv @@
module fdf_chk #(
	parameter int TAPS        = 8,
	parameter int SAMPLE_BITS = 24,
	parameter int OW          = 32
) (
	input logic          clk,
	input logic          arst_n,
	input logic          s_axis_tvalid,
	input logic          s_axis_tready,
	input logic          s_axis_tlast,
	input logic          m_axis_tvalid,
	input logic          m_axis_tready,
	input logic [OW-1:0] m_axis_tdata,
	input logic          m_axis_tlast
);

	localparam int LAT = TAPS - 1 - TAPS / 2;
	localparam logic [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output word changed while stalled");

	// tail of a frame blocks new samples
	a_flush_block: assert property (@(posedge clk) disable iff (!arst_n)
		(LAT > 0) && s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
		else $error("sample taken during frame tail");

	a_sat_clip: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[SAMPLE_BITS] |->
			(m_axis_tdata[SAMPLE_BITS-1:0] == SMAX) || (m_axis_tdata[SAMPLE_BITS-1:0] == SMIN))
		else $error("saturation flag without clipped value");

endmodule

bind fractional_delay_fir_frame_core fdf_chk #(
	.TAPS       (TAPS),
	.SAMPLE_BITS(SAMPLE_BITS),
	.OW         (OW)
) u_fdf_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tlast (s_axis_tlast),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tlast (m_axis_tlast)
);

@@ bench/fractional_delay_fir_frame_core_tb.sv @@
`timescale 1ns / 100ps

module fractional_delay_fir_frame_core_tb;

	localparam int TAPS = 8;
	localparam int LAT = TAPS - 1 - TAPS / 2;
	localparam int IDX_W = fdf_pkg::IDX_W;
	localparam logic [23:0] SAMPLE_MAX = 24'h7fffff;
	localparam logic [23:0] SAMPLE_MIN = 24'h800000;
	localparam logic [15:0] COEF_MAX = 16'h7fff;
	localparam logic [15:0] COEF_MIN = 16'h8000;
	localparam logic [15:0] COEF_HALF = 16'h4000;
	localparam int CENTER_TAP = TAPS / 2;

	class fir_scoreboard;
		typedef struct {
			logic [23:0] value;
			logic        sat;
			logic        last;
		} fir_word_t;

		fir_word_t          pending[$];
		logic signed [15:0] coef[TAPS];
		logic signed [23:0] hist[TAPS-1];
		logic signed [23:0] window[TAPS];
		int                 fill;
		int                 errors;

		function new();
			foreach (coef[k]) coef[k] = 0;
			coef[CENTER_TAP] = COEF_MAX;
			foreach (hist[m]) hist[m] = 0;
			fill = 0;
			errors = 0;
		endfunction

		function void set_coef(int idx, logic [15:0] value);
			coef[idx] = value;
		endfunction

		// window shifted by d, taps falling off the end see zero padding
		function void push_output(int d, bit last);
			longint    acc;
			longint    r;
			fir_word_t w;
			acc = 0;
			for (int k = 0; k < TAPS; k++) begin
				if (k + d < TAPS)
					acc += longint'(coef[k]) * longint'(window[k + d]);
			end
			r = (acc + 64'sd16384) >>> 15;
			w.sat = 1'b0;
			if (r > 64'sd8388607) begin
				r = 64'sd8388607;
				w.sat = 1'b1;
			end else if (r < -64'sd8388608) begin
				r = -64'sd8388608;
				w.sat = 1'b1;
			end
			w.value = r[23:0];
			w.last = last;
			pending.push_back(w);
		endfunction

		function void note_input(logic [23:0] s, logic frame_end);
			for (int m = 0; m < TAPS - 1; m++) window[m] = hist[m];
			window[TAPS-1] = s;
			if (frame_end) begin
				for (int d = LAT - fill; d <= LAT; d++) push_output(d, d == LAT);
				foreach (hist[m]) hist[m] = 0;
				fill = 0;
			end else begin
				if (fill >= LAT) push_output(0, 1'b0);
				for (int m = 0; m < TAPS - 1; m++) hist[m] = window[m + 1];
				if (fill < LAT) fill++;
			end
		endfunction

		function void check_result(logic [31:0] data, logic last);
			fir_word_t w;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected word: sample %0d sat %0b last %0b",
						$signed(data[23:0]), data[24], last);
				return;
			end
			w = pending.pop_front();
			if (data[23:0] !== w.value || data[24] !== w.sat || last !== w.last) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected %0d sat %0b last %0b, got %0d sat %0b last %0b",
						$signed(w.value), w.sat, w.last, $signed(data[23:0]), data[24], last);
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [23:0]      s_axis_tdata;
	logic             s_axis_tlast;
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [31:0]      m_axis_tdata;
	logic             m_axis_tlast;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_idx;
	logic [15:0]      cfg_data;

	fir_scoreboard sb = new();
	bit            quiet = 1'b0;
	bit            long_hold = 1'b0;

	fractional_delay_fir_frame_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data)
	);

	always #10 clk = ~clk;

	function automatic logic [23:0] pick_sample();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return 24'(int'($urandom_range(0, 15)) - 8);
			3, 4, 5: return 24'(int'($urandom_range(0, 8191)) - 4096);
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_coef();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return COEF_MAX;
			1: return COEF_MIN;
			2: return 16'h0000;
			3, 4, 5, 6: return 16'(int'($urandom_range(0, 8191)) - 4096);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic write_coefs(input logic [15:0] vals[TAPS]);
		for (int i = 0; i < TAPS; i++) begin
			cfg_we <= 1'b1;
			cfg_idx <= IDX_W'(i);
			cfg_data <= vals[i];
			@(posedge clk);
			sb.set_coef(i, vals[i]);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic send_word(input logic [23:0] s, input logic frame_end);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= s;
		s_axis_tlast <= frame_end;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_input(s, frame_end);
	endtask

	task automatic send_frame(input int len);
		for (int i = 0; i < len; i++) send_word(pick_sample(), i == len - 1);
	endtask

	// sender pauses until every expected word is back and the tail has drained
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// receiver with random stalls and one long hold-off
	initial begin
		int stall_left;
		stall_left = 0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
			if (long_hold) begin
				long_hold = 1'b0;
				stall_left = 60;
			end
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				stall_left = $urandom_range(1, 4) - 1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		#8000000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		logic [15:0] c[TAPS];
		int          count;
		int          len;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tlast <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= '0;
		cfg_data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// positive and negative clipping with full-scale taps
		foreach (c[i]) c[i] = COEF_MAX;
		write_coefs(c);
		for (int i = 0; i < 4; i++) send_word(SAMPLE_MAX, 1'b0);
		send_word(SAMPLE_MAX, 1'b1);
		send_word(SAMPLE_MIN, 1'b1);
		send_word(SAMPLE_MIN, 1'b0);
		send_word(SAMPLE_MIN, 1'b1);
		settle();

		foreach (c[i]) c[i] = COEF_MIN;
		write_coefs(c);
		send_word(SAMPLE_MAX, 1'b0);
		send_word(SAMPLE_MIN, 1'b0);
		send_word(SAMPLE_MAX, 1'b1);
		for (int i = 0; i < 3; i++) send_word(SAMPLE_MIN, 1'b0);
		send_word(SAMPLE_MIN, 1'b1);
		settle();

		// half-scale center tap hits the round-half-up boundary
		foreach (c[i]) c[i] = 16'h0000;
		c[CENTER_TAP] = COEF_HALF;
		write_coefs(c);
		send_word(24'd1, 1'b0);
		send_word(24'hffffff, 1'b0);
		send_word(24'd3, 1'b0);
		send_word(24'hfffffd, 1'b0);
		send_word(SAMPLE_MAX, 1'b0);
		send_word(SAMPLE_MIN, 1'b1);
		settle();

		for (int p = 0; p < 6; p++) begin
			if (p == 5) quiet = 1'b1;
			foreach (c[i]) c[i] = pick_coef();
			write_coefs(c);
			if (p == 1) begin
				long_hold = 1'b1;
				send_frame(24);
			end
			count = 0;
			while (count < 42) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
				send_frame(len);
				count += len;
			end
			settle();
		end

		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
